// ===== src/dac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dac_pkg;

	// queue of held send requests
	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// status map: 64 rows of 32 bits, one bit per accessory address
	localparam int STATUS_WORDS = 64;
	localparam int STATUS_BITS  = 32;
	localparam int SROW_W       = $clog2(STATUS_WORDS);
	localparam int SBIT_W       = $clog2(STATUS_BITS);

	localparam int ADDR_W           = 11;
	localparam int SLOTS_W          = 5;
	localparam int REP_W            = 4;
	localparam int MAX_RESULTS      = 16;
	localparam int RES_W            = $clog2(MAX_RESULTS + 1);
	localparam int LAST_STORED_ADDR = 2044;
	localparam logic [REP_W-1:0] REPEAT_RESET = 4'd4;

	// actions
	localparam logic [1:0] ACT_SEND  = 2'd0;
	localparam logic [1:0] ACT_RETRY = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	// result kinds loaded into the output register
	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_DROP  = 2'd1;
	localparam logic [1:0] KIND_PKT   = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd3;

	// register indexes
	localparam logic REG_REPEAT = 1'b0;

	typedef struct packed {
		logic       load_in;
		logic       q_push;
		logic       q_read;
		logic       q_pop;
		logic       st_read;
		logic       out_load;
		logic [1:0] out_kind;
		logic       out_accepted;
		logic       out_last;
	} dac_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       slots_nz;
		logic       q_full;
		logic       more;
		logic       out_free;
	} dac_stat_t;

endpackage

`default_nettype wire

// ===== src/dcc_accessory_command_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Signals                      | Contents
// s_*      | in  | tvalid tready tdata tuser    | command: action, address, closed, slots
// m_*      | out | tvalid tready tdata tuser    | result: packet bytes, flags; tlast per
//          |     | tlast                        | command
// APB      | in  | psel penable pwrite paddr    | repeat_count at byte address 0
//          |     | pwdata prdata pready         |
//
// Send with room or query: dispatch, status row read, then the result is loaded on emit.
// Queued or dropped sends, empty ticks and unused actions: result loaded from dispatch.
// A retry tick, per packet: queue read, entry load, status row read, emit with write
// back. Reset empties the queue and leaves the status map reading all closed. An
// untaken result holds the unit in dispatch or emit; one further command is accepted
// while it waits.

module dcc_accessory_command_unit
	import dac_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // address[10:0], closed[11], sink_slots[16:12]
	input  wire  [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // address_byte, data_byte, check_byte, packet_address,
	                               // repeat_times, accepted, dropped, status_closed
	output logic [0:0]  m_tuser,   // packet_valid
	output logic        m_tlast,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dac_cmd_t        cmd;
	dac_stat_t       stat;
	logic [REP_W-1:0] repeat_q;
	logic             pkt_valid;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_q <= REPEAT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_REPEAT)) begin
			repeat_q <= pwdata[REP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_REPEAT) ? {{(32 - REP_W){1'b0}}, repeat_q} : '0;

	dac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dac_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_action        (s_tuser),
		.in_address       (s_tdata[10:0]),
		.in_closed        (s_tdata[11]),
		.in_slots         (s_tdata[16:12]),
		.repeat_count     (repeat_q),
		.cmd              (cmd),
		.stat             (stat),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_data         (m_tdata),
		.out_packet_valid (pkt_valid),
		.out_last         (m_tlast)
	);

	assign m_tuser = pkt_valid;

endmodule

`default_nettype wire

// ===== src/dac_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dac_ctrl
	import dac_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_ready,
	input  dac_stat_t stat,
	output dac_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_Q_RD     = 3'd2;
	localparam logic [2:0] ST_Q_LOAD   = 3'd3;
	localparam logic [2:0] ST_STAT_RD  = 3'd4;
	localparam logic [2:0] ST_EMIT     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.action)
					ACT_SEND: begin
						if (stat.slots_nz) begin
							state_d = ST_STAT_RD;
						end else if (stat.out_free) begin
							cmd.out_load = 1'b1;
							cmd.out_kind = stat.q_full ? KIND_DROP : KIND_EMPTY;
							cmd.q_push   = !stat.q_full;
							cmd.out_last = 1'b1;
							state_d      = ST_IDLE;
						end
					end
					ACT_RETRY: begin
						if (stat.more) begin
							state_d = ST_Q_RD;
						end else if (stat.out_free) begin
							cmd.out_load = 1'b1;
							cmd.out_kind = KIND_EMPTY;
							cmd.out_last = 1'b1;
							state_d      = ST_IDLE;
						end
					end
					ACT_QUERY: begin
						state_d = ST_STAT_RD;
					end
					default: begin
						if (stat.out_free) begin
							cmd.out_load = 1'b1;
							cmd.out_kind = KIND_EMPTY;
							cmd.out_last = 1'b1;
							state_d      = ST_IDLE;
						end
					end
				endcase
			end
			ST_Q_RD: begin
				cmd.q_read = 1'b1;
				state_d    = ST_Q_LOAD;
			end
			ST_Q_LOAD: begin
				cmd.q_pop = 1'b1;
				state_d   = ST_STAT_RD;
			end
			ST_STAT_RD: begin
				cmd.st_read = 1'b1;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_kind     = (stat.action == ACT_QUERY) ? KIND_QUERY : KIND_PKT;
					cmd.out_accepted = (stat.action == ACT_SEND);
					// queue and slot state already reflect this pop
					cmd.out_last     = (stat.action != ACT_RETRY) || !stat.more;
					state_d = ((stat.action == ACT_RETRY) && stat.more) ? ST_Q_RD : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/dac_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dac_datapath
	import dac_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire  [1:0]         in_action,
	input  wire  [ADDR_W-1:0]  in_address,
	input  wire                in_closed,
	input  wire  [SLOTS_W-1:0] in_slots,
	input  wire  [REP_W-1:0]   repeat_count,
	input  dac_cmd_t           cmd,
	output dac_stat_t          stat,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [47:0]        out_data,
	output logic               out_packet_valid,
	output logic               out_last
);

	// command registers
	logic [1:0]         action_q;
	logic [SLOTS_W-1:0] slots_q;
	logic [RES_W-1:0]   sent_q;
	logic [ADDR_W-1:0]  cur_addr_q;
	logic               cur_closed_q;

	// queue
	logic [ADDR_W:0]    q_mem [QUEUE_DEPTH];
	logic [ADDR_W:0]    q_rdata_q;
	logic [QPTR_W-1:0]  head_q;
	logic [QPTR_W-1:0]  tail_q;
	logic [QCNT_W-1:0]  count_q;

	// status map, rows not yet written read as zero
	logic [STATUS_BITS-1:0] st_mem [STATUS_WORDS];
	logic [STATUS_WORDS-1:0] st_vld_q;
	logic [STATUS_BITS-1:0] st_rdata_q;
	logic                   st_rvld_q;

	// output register
	logic               out_valid_q;
	logic               out_pv_q;
	logic [7:0]         out_b0_q;
	logic [7:0]         out_b1_q;
	logic [7:0]         out_ck_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [REP_W-1:0]   out_rep_q;
	logic               out_acc_q;
	logic               out_drop_q;
	logic               out_sc_q;
	logic               out_last_q;

	logic [SROW_W-1:0]      row;
	logic [SBIT_W-1:0]      bitpos;
	logic                   storable;
	logic [STATUS_BITS-1:0] cur_word;
	logic [STATUS_BITS-1:0] new_word;
	logic [9:0]             grp;
	logic [2:0]             inv;
	logic [7:0]             b0;
	logic [7:0]             b1;
	logic                   st_write;

	assign row      = cur_addr_q[ADDR_W-1:SBIT_W];
	assign bitpos   = cur_addr_q[SBIT_W-1:0];
	assign storable = (cur_addr_q <= ADDR_W'(LAST_STORED_ADDR));
	assign cur_word = st_rvld_q ? st_rdata_q : '0;

	always_comb begin
		new_word         = cur_word;
		new_word[bitpos] = !cur_closed_q;
	end

	assign grp = {1'b0, cur_addr_q[ADDR_W-1:2]} + 10'd1;
	assign inv = ~grp[8:6];
	assign b0  = {2'b10, grp[5:0]};
	assign b1  = {1'b1, inv, 1'b1, cur_addr_q[1:0], cur_closed_q};

	assign st_write = cmd.out_load && (cmd.out_kind == KIND_PKT) && storable;

	assign stat.action   = action_q;
	assign stat.slots_nz = (slots_q != '0);
	assign stat.q_full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.more     = (count_q != '0) && (slots_q != '0)
		&& (sent_q < RES_W'(MAX_RESULTS));
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			action_q     <= in_action;
			cur_addr_q   <= in_address;
			cur_closed_q <= in_closed;
		end else if (cmd.q_pop) begin
			cur_addr_q   <= q_rdata_q[ADDR_W-1:0];
			cur_closed_q <= q_rdata_q[ADDR_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
			sent_q  <= '0;
		end else if (cmd.load_in) begin
			slots_q <= in_slots;
			sent_q  <= '0;
		end else if (cmd.q_pop) begin
			slots_q <= slots_q - SLOTS_W'(1);
			sent_q  <= sent_q + RES_W'(1);
		end
	end

	// queue storage and read port
	always_ff @(posedge clk) begin
		if (cmd.q_push) begin
			q_mem[tail_q] <= {cur_closed_q, cur_addr_q};
		end
		if (cmd.q_read) begin
			q_rdata_q <= q_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.q_push) begin
				tail_q  <= (tail_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QPTR_W'(1);
				count_q <= count_q + QCNT_W'(1);
			end else if (cmd.q_pop) begin
				head_q  <= (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QPTR_W'(1);
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// status map: read-modify-write, row read registered, written on emit
	always_ff @(posedge clk) begin
		if (cmd.st_read) begin
			st_rdata_q <= st_mem[row];
		end
		if (st_write) begin
			st_mem[row] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q  <= '0;
			st_rvld_q <= 1'b0;
		end else begin
			if (cmd.st_read) begin
				st_rvld_q <= st_vld_q[row];
			end
			if (st_write) begin
				st_vld_q[row] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pv_q   <= 1'b0;
			out_b0_q   <= '0;
			out_b1_q   <= '0;
			out_ck_q   <= '0;
			out_addr_q <= '0;
			out_rep_q  <= '0;
			out_acc_q  <= 1'b0;
			out_drop_q <= 1'b0;
			out_sc_q   <= 1'b0;
			out_last_q <= cmd.out_last;
			case (cmd.out_kind)
				KIND_PKT: begin
					out_pv_q   <= 1'b1;
					out_b0_q   <= b0;
					out_b1_q   <= b1;
					out_ck_q   <= b0 ^ b1;
					out_addr_q <= cur_addr_q;
					out_rep_q  <= repeat_count;
					out_acc_q  <= cmd.out_accepted;
				end
				KIND_QUERY: begin
					out_sc_q <= !storable || !cur_word[bitpos];
				end
				KIND_DROP: begin
					out_drop_q <= 1'b1;
				end
				default: begin
					out_pv_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign out_packet_valid = out_pv_q;
	assign out_last         = out_last_q;
	assign out_data = {6'd0, out_sc_q, out_drop_q, out_acc_q, out_rep_q, out_addr_q,
		out_ck_q, out_b1_q, out_b0_q};

endmodule

`default_nettype wire
